FILE: hw/rtl/ofdmsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ofdmsc_pkg;

   // Block geometry
   localparam int MAX_FFT       = 4096;
   localparam int PILOT_SPACING = 12;

   localparam int IDX_W   = 12;  // subcarrier index and rank
   localparam int SIZE_W  = 13;  // fft_size, data_sc_num
   localparam int POFF_W  = 4;   // pilot_offset
   localparam int CSR_W   = 13;  // widest register
   localparam int CSR_IDX_W = 2;

   // 802.11a layout used when fft_size is 64
   localparam int WIFI_FFT      = 64;
   localparam int WIFI_IDX_W    = 6;
   localparam int WIFI_NULL_LO  = 27;
   localparam int WIFI_NULL_HI  = 37;
   localparam int WIFI_NULL_CNT = 12;
   localparam int WIFI_PILOT_CNT = 4;
   localparam logic [WIFI_IDX_W-1:0] WIFI_PILOTS [WIFI_PILOT_CNT] = '{
      6'd7, 6'd21, 6'd43, 6'd57
   };

   // Reciprocal divide by PILOT_SPACING: q = (t * RECIP) >> DIV_SHIFT.
   // DIV_SHIFT is large enough that the quotient is exact for every 12-bit t
   // and that the low DIV_SHIFT product bits stay below RECIP exactly when
   // t is a multiple of the spacing.
   localparam int DIV_SHIFT = 19;
   localparam int RECIP     = (2 ** DIV_SHIFT + PILOT_SPACING - 1) / PILOT_SPACING;
   localparam int PROD_W    = IDX_W + DIV_SHIFT;

   // Register reset values
   localparam logic [SIZE_W-1:0] FFT_SIZE_RST     = SIZE_W'(64);
   localparam logic [SIZE_W-1:0] DATA_SC_NUM_RST  = SIZE_W'(48);
   localparam logic [POFF_W-1:0] PILOT_OFFSET_RST = '0;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FFT_SIZE     = 2'd0,
      CSR_DATA_SC_NUM  = 2'd1,
      CSR_PILOT_OFFSET = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      CLS_NULL  = 2'd0,
      CLS_DATA  = 2'd1,
      CLS_PILOT = 2'd2,
      CLS_OUT   = 2'd3
   } sc_class_type;

   typedef struct packed {
      sc_class_type      sc_class;
      logic [IDX_W-1:0]  sc_rank;
   } cls_rank_type;

   // Fixed 802.11a map for an index below 64
   function automatic cls_rank_type wifi_classify(input logic [WIFI_IDX_W-1:0] idx);
      cls_rank_type res;
      logic [IDX_W-1:0] nulls_below;
      logic [IDX_W-1:0] pilots_below;
      logic             is_pilot;
      logic [IDX_W-1:0] pilot_rank;
      nulls_below  = '0;
      pilots_below = '0;
      is_pilot     = 1'b0;
      pilot_rank   = '0;
      for (int k = 0; k < WIFI_PILOT_CNT; k++) begin
         if (idx == WIFI_PILOTS[k]) begin
            is_pilot   = 1'b1;
            pilot_rank = IDX_W'(k);
         end
         if (idx > WIFI_PILOTS[k]) pilots_below = pilots_below + IDX_W'(1);
      end
      if (idx > WIFI_IDX_W'(WIFI_NULL_HI)) nulls_below = IDX_W'(WIFI_NULL_CNT);
      else if (idx != '0)                  nulls_below = IDX_W'(1);

      if (idx == '0) begin
         res.sc_class = CLS_NULL;
         res.sc_rank  = '0;
      end else if (idx >= WIFI_IDX_W'(WIFI_NULL_LO) && idx <= WIFI_IDX_W'(WIFI_NULL_HI)) begin
         res.sc_class = CLS_NULL;
         res.sc_rank  = IDX_W'(idx) - IDX_W'(WIFI_NULL_LO - 1);
      end else if (is_pilot) begin
         res.sc_class = CLS_PILOT;
         res.sc_rank  = pilot_rank;
      end else begin
         res.sc_class = CLS_DATA;
         res.sc_rank  = IDX_W'(idx) - nulls_below - pilots_below;
      end
      return res;
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/ofdm_subcarrier_classifier.sv
`timescale 1ns / 1ps
`default_nettype none

// OFDM subcarrier classifier. Each req item carries one subcarrier index;
// each rsp item returns its class (null, data, pilot, or out of range) and
// its rank within that class's ascending list. With fft_size 64 the fixed
// 802.11a map applies; otherwise a centred block of data_sc_num carriers
// holds the data, with a pilot every PILOT_SPACING carriers starting at
// pilot_offset, and everything outside the block is null. The block takes
// one item per cycle while the result side does not stall. It has an input
// register, one pass of classification logic whose longest path is the
// reciprocal multiply that divides by the pilot spacing, and a result
// register. A stalled result holds in the result register while the input
// register still takes one more item. Write the csr registers only while no
// item is in flight; the derived block bounds settle in the cycle after a write.
module ofdm_subcarrier_classifier (
   input  wire                                 clock,
   input  wire                                 reset,
   // configuration
   input  wire                                 csr_wr_en,
   input  wire  [ofdmsc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire  [ofdmsc_pkg::CSR_W-1:0]        csr_wr_data,
   // request channel
   input  wire                                 req_valid,
   output logic                                req_stall,
   input  wire  [ofdmsc_pkg::IDX_W-1:0]        req_sc_index,
   // response channel
   output logic                                rsp_valid,
   input  wire                                 rsp_stall,
   output ofdmsc_pkg::sc_class_type            rsp_sc_class,
   output logic [ofdmsc_pkg::IDX_W-1:0]        rsp_sc_rank
);
   import ofdmsc_pkg::*;

   // Configuration registers
   logic [SIZE_W-1:0] fft_size_ff;
   logic [SIZE_W-1:0] data_sc_num_ff;
   logic [POFF_W-1:0] pilot_offset_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fft_size_ff     <= FFT_SIZE_RST;
         data_sc_num_ff  <= DATA_SC_NUM_RST;
         pilot_offset_ff <= PILOT_OFFSET_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_FFT_SIZE:     fft_size_ff     <= csr_wr_data;
            CSR_DATA_SC_NUM:  data_sc_num_ff  <= csr_wr_data;
            CSR_PILOT_OFFSET: pilot_offset_ff <= csr_wr_data[POFF_W-1:0];
            default: ;  // unmapped index: drop the write
         endcase
      end
   end

   // Derived layout, registered to keep it off the per-item path.
   // n: effective FFT size, start/stop: bounds of the centred data block.
   logic [SIZE_W-1:0] n_in,     n_ff;
   logic [SIZE_W-1:0] d_in;
   logic [IDX_W-1:0]  start_in, start_ff;
   logic [SIZE_W-1:0] stop_in,  stop_ff;
   logic              wifi_in,  wifi_ff;
   logic [SIZE_W-1:0] spare;

   always_comb begin
      n_in     = (fft_size_ff > SIZE_W'(MAX_FFT)) ? SIZE_W'(MAX_FFT) : fft_size_ff;
      d_in     = (data_sc_num_ff > n_in) ? n_in : data_sc_num_ff;
      spare    = n_in - d_in;
      start_in = spare[SIZE_W-1:1];
      stop_in  = SIZE_W'(start_in) + d_in;
      wifi_in  = (fft_size_ff == SIZE_W'(WIFI_FFT));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff     <= SIZE_W'(WIFI_FFT);
         start_ff <= IDX_W'(8);
         stop_ff  <= SIZE_W'(56);
         wifi_ff  <= 1'b1;
      end else begin
         n_ff     <= n_in;
         start_ff <= start_in;
         stop_ff  <= stop_in;
         wifi_ff  <= wifi_in;
      end
   end

   // Handshake: the result register loads when empty or being drained;
   // the input register loads when empty or moving into the result.
   logic             s1_valid_ff;
   logic [IDX_W-1:0] s1_idx_ff;
   logic             rsp_valid_ff;
   logic             out_load;
   logic             req_take;

   assign out_load  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !out_load;
   assign req_take  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!s1_valid_ff || out_load) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) s1_idx_ff <= req_sc_index;
   end

   // Classification of the registered index
   logic [IDX_W-1:0]  rel;
   logic [IDX_W-1:0]  poff_gap;
   logic              past_offset;
   logic [PROD_W-1:0] prod;
   logic [IDX_W-1:0]  quot;
   logic              on_pilot;
   cls_rank_type      res_in;
   cls_rank_type      res_ff;

   always_comb begin
      rel         = s1_idx_ff - start_ff;
      past_offset = (rel >= IDX_W'(pilot_offset_ff));
      poff_gap    = rel - IDX_W'(pilot_offset_ff);
      prod        = PROD_W'(poff_gap) * PROD_W'(RECIP);
      quot        = prod[DIV_SHIFT +: IDX_W];
      // low product bits below the reciprocal: poff_gap is a multiple of the spacing
      on_pilot    = past_offset && (prod[DIV_SHIFT-1:0] < DIV_SHIFT'(RECIP));

      if (SIZE_W'(s1_idx_ff) >= n_ff) begin
         res_in.sc_class = CLS_OUT;
         res_in.sc_rank  = '0;
      end else if (wifi_ff) begin
         res_in = wifi_classify(s1_idx_ff[WIFI_IDX_W-1:0]);
      end else if (s1_idx_ff < start_ff) begin
         res_in.sc_class = CLS_NULL;
         res_in.sc_rank  = s1_idx_ff;
      end else if (SIZE_W'(s1_idx_ff) >= stop_ff) begin
         // nulls above the block follow the ones below it
         res_in.sc_class = CLS_NULL;
         res_in.sc_rank  = IDX_W'(SIZE_W'(s1_idx_ff) - stop_ff + SIZE_W'(start_ff));
      end else if (on_pilot) begin
         res_in.sc_class = CLS_PILOT;
         res_in.sc_rank  = quot;
      end else if (past_offset) begin
         // not a pilot, so ceil(poff_gap / spacing) pilots lie below
         res_in.sc_class = CLS_DATA;
         res_in.sc_rank  = rel - quot - IDX_W'(1);
      end else begin
         res_in.sc_class = CLS_DATA;
         res_in.sc_rank  = rel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load && s1_valid_ff) res_ff <= res_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_sc_class = res_ff.sc_class;
   assign rsp_sc_rank  = res_ff.sc_rank;

endmodule

`default_nettype wire

FILE: hw/rtl/ofdmsc_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module ofdmsc_checker (
   input wire                                 clock,
   input wire                                 reset,
   input wire                                 req_stall,
   input wire                                 rsp_valid,
   input wire                                 rsp_stall,
   input wire ofdmsc_pkg::sc_class_type       rsp_sc_class,
   input wire [ofdmsc_pkg::IDX_W-1:0]         rsp_sc_rank
);
   import ofdmsc_pkg::*;

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_sc_class) && $stable(rsp_sc_rank))
      else $error("stalled rsp item changed");

   // out-of-range index reports rank zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_sc_class == CLS_OUT) |-> (rsp_sc_rank == '0))
      else $error("out-of-range rsp item with nonzero rank");

   // no result right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

   // req is stalled only while a result is held back
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || !rsp_stall) |-> !req_stall)
      else $error("req stalled while result side is free");

endmodule

bind ofdm_subcarrier_classifier ofdmsc_checker u_ofdmsc_checker (
   .clock        (clock),
   .reset        (reset),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_sc_class (rsp_sc_class),
   .rsp_sc_rank  (rsp_sc_rank)
);

`default_nettype wire

FILE: dv/tb_ofdm_subcarrier_classifier.sv
`timescale 1ns / 1ps

module tb_ofdm_subcarrier_classifier;
   import ofdmsc_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int RAND_PHASES   = 14;
   localparam int PHASE_ITEMS   = 30;
   localparam int HOLD_CYCLES   = 200;  // long receiver hold-off to back up the pipe
   localparam int DRAIN_CYCLES  = 4;    // covers the two pipeline stages plus margin
   localparam int SETTLE_CYCLES = 2;    // derived block bounds settle in the cycle after a write

   // Fixed 802.11a carrier map
   localparam int WIFI_NULL_SET  [12] = '{0, 27, 28, 29, 30, 31, 32, 33, 34, 35, 36, 37};
   localparam int WIFI_PILOT_SET [4]  = '{7, 21, 43, 57};

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   // One directed step: either a register write or an item. Items marked as
   // typed carry their expected class and rank; the rest use the predictor.
   typedef struct packed {
      row_kind_type     kind;
      csr_index_type    csr_ix;
      logic [CSR_W-1:0] wdata;
      logic [IDX_W-1:0] sc_index;
      logic             typed;
      sc_class_type     cls;
      logic [IDX_W-1:0] rank;
   } stim_row_type;

   typedef struct packed {
      logic [IDX_W-1:0] sc_index;
      cls_rank_type     res;
   } carrier_verdict_type;

   localparam int DIR_ROWS = 35;
   stim_row_type dir_rows [DIR_ROWS] = '{
      // reset map (802.11a): edges of the null band, pilots, both ends of the data
      '{ROW_ITEM, CSR_FFT_SIZE,     13'd0,    12'd0,    1'b1, CLS_NULL,  12'd0},
      '{ROW_ITEM, CSR_FFT_SIZE,     13'd0,    12'd7,    1'b1, CLS_PILOT, 12'd0},
      '{ROW_ITEM, CSR_FFT_SIZE,     13'd0,    12'd57,   1'b1, CLS_PILOT, 12'd3},
      '{ROW_ITEM, CSR_FFT_SIZE,     13'd0,    12'd27,   1'b1, CLS_NULL,  12'd1},
      '{ROW_ITEM, CSR_FFT_SIZE,     13'd0,    12'd37,   1'b1, CLS_NULL,  12'd11},
      '{ROW_ITEM, CSR_FFT_SIZE,     13'd0,    12'd1,    1'b1, CLS_DATA,  12'd0},
      '{ROW_ITEM, CSR_FFT_SIZE,     13'd0,    12'd63,   1'b1, CLS_DATA,  12'd47},
      '{ROW_ITEM, CSR_FFT_SIZE,     13'd0,    12'd64,   1'b1, CLS_OUT,   12'd0},
      '{ROW_ITEM, CSR_FFT_SIZE,     13'd0,    12'd4095, 1'b1, CLS_OUT,   12'd0},
      '{ROW_ITEM, CSR_FFT_SIZE,     13'd0,    12'd38,   1'b0, CLS_NULL,  12'd0},
      // size above the maximum clamps to 4096; pilot offset beyond the spacing
      '{ROW_CSR,  CSR_FFT_SIZE,     13'd8191, 12'd0,    1'b0, CLS_NULL,  12'd0},
      '{ROW_CSR,  CSR_DATA_SC_NUM,  13'd4096, 12'd0,    1'b0, CLS_NULL,  12'd0},
      '{ROW_CSR,  CSR_PILOT_OFFSET, 13'd15,   12'd0,    1'b0, CLS_NULL,  12'd0},
      '{ROW_ITEM, CSR_FFT_SIZE,     13'd0,    12'd15,   1'b1, CLS_PILOT, 12'd0},
      '{ROW_ITEM, CSR_FFT_SIZE,     13'd0,    12'd0,    1'b1, CLS_DATA,  12'd0},
      '{ROW_ITEM, CSR_FFT_SIZE,     13'd0,    12'd4095, 1'b0, CLS_NULL,  12'd0},
      // zero size: everything is out of range
      '{ROW_CSR,  CSR_FFT_SIZE,     13'd0,    12'd0,    1'b0, CLS_NULL,  12'd0},
      '{ROW_ITEM, CSR_FFT_SIZE,     13'd0,    12'd0,    1'b1, CLS_OUT,   12'd0},
      '{ROW_ITEM, CSR_FFT_SIZE,     13'd0,    12'd4095, 1'b1, CLS_OUT,   12'd0},
      // data count above the size clamps to the size
      '{ROW_CSR,  CSR_FFT_SIZE,     13'd100,  12'd0,    1'b0, CLS_NULL,  12'd0},
      '{ROW_CSR,  CSR_DATA_SC_NUM,  13'd8191, 12'd0,    1'b0, CLS_NULL,  12'd0},
      '{ROW_CSR,  CSR_PILOT_OFFSET, 13'd11,   12'd0,    1'b0, CLS_NULL,  12'd0},
      '{ROW_ITEM, CSR_FFT_SIZE,     13'd0,    12'd11,   1'b1, CLS_PILOT, 12'd0},
      '{ROW_ITEM, CSR_FFT_SIZE,     13'd0,    12'd99,   1'b0, CLS_NULL,  12'd0},
      '{ROW_ITEM, CSR_FFT_SIZE,     13'd0,    12'd50,   1'b0, CLS_NULL,  12'd0},
      // empty data block: the whole band is null
      '{ROW_CSR,  CSR_FFT_SIZE,     13'd4096, 12'd0,    1'b0, CLS_NULL,  12'd0},
      '{ROW_CSR,  CSR_DATA_SC_NUM,  13'd0,    12'd0,    1'b0, CLS_NULL,  12'd0},
      '{ROW_ITEM, CSR_FFT_SIZE,     13'd0,    12'd0,    1'b1, CLS_NULL,  12'd0},
      '{ROW_ITEM, CSR_FFT_SIZE,     13'd0,    12'd4095, 1'b0, CLS_NULL,  12'd0},
      '{ROW_ITEM, CSR_FFT_SIZE,     13'd0,    12'd2048, 1'b0, CLS_NULL,  12'd0},
      // one above the 802.11a size takes the generic layout
      '{ROW_CSR,  CSR_FFT_SIZE,     13'd65,   12'd0,    1'b0, CLS_NULL,  12'd0},
      '{ROW_CSR,  CSR_DATA_SC_NUM,  13'd48,   12'd0,    1'b0, CLS_NULL,  12'd0},
      '{ROW_CSR,  CSR_PILOT_OFFSET, 13'd0,    12'd0,    1'b0, CLS_NULL,  12'd0},
      '{ROW_ITEM, CSR_FFT_SIZE,     13'd0,    12'd7,    1'b0, CLS_NULL,  12'd0},
      '{ROW_ITEM, CSR_FFT_SIZE,     13'd0,    12'd64,   1'b0, CLS_NULL,  12'd0}
   };

   // DUT signals; the inputs are all known from time zero
   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_wr_data = '0;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [IDX_W-1:0]     req_sc_index = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   sc_class_type         rsp_sc_class;
   logic [IDX_W-1:0]     rsp_sc_rank;

   // Mirror of the configuration registers, updated as each write lands
   logic [SIZE_W-1:0] fft_size_q  = FFT_SIZE_RST;
   logic [SIZE_W-1:0] data_sc_q   = DATA_SC_NUM_RST;
   logic [POFF_W-1:0] pilot_off_q = PILOT_OFFSET_RST;

   carrier_verdict_type verdict_q [$];  // classifications still owed by the DUT
   int  error_count = 0;
   int  cycle_count = 0;
   bit  tx_quiet = 1'b0;      // sender offers back to back
   bit  rx_quiet = 1'b0;      // receiver never stalls
   bit  hold_request = 1'b0;  // ask the receiver for one long hold-off

   ofdm_subcarrier_classifier dut (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wr_data  (csr_wr_data),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_sc_index (req_sc_index),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_sc_class (rsp_sc_class),
      .rsp_sc_rank  (rsp_sc_rank)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Classify one carrier against the mirrored configuration.
   function automatic cls_rank_type classify_index(input logic [IDX_W-1:0] idx);
      cls_rank_type res;
      int n, d, first, past, rel, poff, i, nulls_below, pilots_below;
      res.sc_class = CLS_OUT;
      res.sc_rank  = '0;
      i    = int'(idx);
      poff = int'(pilot_off_q);
      n    = (int'(fft_size_q) > MAX_FFT) ? MAX_FFT : int'(fft_size_q);
      if (i >= n) return res;
      if (int'(fft_size_q) == WIFI_FFT) begin
         nulls_below  = 0;
         pilots_below = 0;
         for (int k = 0; k < 12; k++) begin
            if (WIFI_NULL_SET[k] == i) begin
               res.sc_class = CLS_NULL;
               res.sc_rank  = IDX_W'(k);
               return res;
            end
            if (WIFI_NULL_SET[k] < i) nulls_below++;
         end
         for (int k = 0; k < 4; k++) begin
            if (WIFI_PILOT_SET[k] == i) begin
               res.sc_class = CLS_PILOT;
               res.sc_rank  = IDX_W'(k);
               return res;
            end
            if (WIFI_PILOT_SET[k] < i) pilots_below++;
         end
         res.sc_class = CLS_DATA;
         res.sc_rank  = IDX_W'(i - nulls_below - pilots_below);
         return res;
      end
      // Generic layout: centred block, null guard on both sides
      d     = (int'(data_sc_q) > n) ? n : int'(data_sc_q);
      first = (n - d) / 2;
      past  = first + d;
      if (i < first) begin
         res.sc_class = CLS_NULL;
         res.sc_rank  = IDX_W'(i);
      end else if (i >= past) begin
         res.sc_class = CLS_NULL;
         res.sc_rank  = IDX_W'(first + i - past);
      end else begin
         rel = i - first;
         if (rel >= poff && (rel - poff) % PILOT_SPACING == 0) begin
            res.sc_class = CLS_PILOT;
            res.sc_rank  = IDX_W'((rel - poff) / PILOT_SPACING);
         end else begin
            // Drop the pilots that sit below this carrier in the block
            res.sc_class = CLS_DATA;
            if (rel > poff)
               res.sc_rank = IDX_W'(rel - (rel - poff + PILOT_SPACING - 1) / PILOT_SPACING);
            else
               res.sc_rank = IDX_W'(rel);
         end
      end
      return res;
   endfunction

   // Mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(5, 30);
   endfunction

   // Favor in-range carriers and the band edges; keep some arbitrary indexes.
   function automatic logic [IDX_W-1:0] pick_index(input int eff);
      int r;
      r = $urandom_range(0, 99);
      if (eff == 0 || r >= 85) return IDX_W'($urandom);
      if (r < 70) return IDX_W'($urandom_range(0, eff - 1));
      if (r < 75) return '0;
      if (r < 80) return IDX_W'(eff - 1);
      return (eff < MAX_FFT) ? IDX_W'(eff) : IDX_W'(MAX_FFT - 1);
   endfunction

   // Offer one item, hold it until accepted, then log what must come back.
   task automatic send_carrier(input logic [IDX_W-1:0] idx, input logic typed,
                               input cls_rank_type typed_res);
      int gap;
      carrier_verdict_type v;
      gap = tx_quiet ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_sc_index <= idx;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      v.sc_index = idx;
      v.res      = typed ? typed_res : classify_index(idx);
      verdict_q.insert(verdict_q.size(), v);
   endtask

   // Stop offering and wait until every owed result has come back.
   task automatic quiesce();
      req_valid <= 1'b0;
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type ix, input logic [CSR_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_index   <= ix;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (ix)
         CSR_FFT_SIZE:     fft_size_q  = value;
         CSR_DATA_SC_NUM:  data_sc_q   = value;
         CSR_PILOT_OFFSET: pilot_off_q = value[POFF_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Receiver: random stall runs, quiet stretches, and one long hold-off
   // counted here while the sender keeps pushing.
   initial begin : rx_stall_gen
      int r;
      int len;
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (rx_quiet) begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
               rsp_stall <= 1'b0;
               len = $urandom_range(1, 20);
            end else if (r < 95) begin
               rsp_stall <= 1'b1;
               len = $urandom_range(1, 4);
            end else begin
               rsp_stall <= 1'b1;
               len = $urandom_range(20, 60);
            end
            repeat (len) @(posedge clock);
         end
      end
   end

   // Check each accepted result against the oldest owed classification.
   always @(posedge clock) begin : rsp_check
      carrier_verdict_type v;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (verdict_q.size() == 0) begin
            $display("%0t: unexpected result class %0d rank %0d", $time,
                     rsp_sc_class, rsp_sc_rank);
            error_count++;
         end else begin
            v = verdict_q.pop_front();
            if (rsp_sc_class !== v.res.sc_class) begin
               $display("%0t: carrier %0d class expected %0d actual %0d", $time,
                        v.sc_index, v.res.sc_class, rsp_sc_class);
               error_count++;
            end
            if (rsp_sc_rank !== v.res.sc_rank) begin
               $display("%0t: carrier %0d rank expected %0d actual %0d", $time,
                        v.sc_index, v.res.sc_rank, rsp_sc_rank);
               error_count++;
            end
         end
      end
   end

   initial begin : stim
      cls_rank_type typed_res;
      int eff;
      logic [CSR_W-1:0] fft_val;
      logic [CSR_W-1:0] data_val;
      int mode;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table: register writes only once the pipe has drained
      for (int row = 0; row < DIR_ROWS; row++) begin
         if (dir_rows[row].kind == ROW_CSR) begin
            quiesce();
            write_csr(dir_rows[row].csr_ix, dir_rows[row].wdata);
            repeat (SETTLE_CYCLES) @(posedge clock);
         end else begin
            typed_res.sc_class = dir_rows[row].cls;
            typed_res.sc_rank  = dir_rows[row].rank;
            send_carrier(dir_rows[row].sc_index, dir_rows[row].typed, typed_res);
         end
      end

      // Random phases: new configuration, then a burst of carriers
      for (int phase = 0; phase < RAND_PHASES; phase++) begin
         quiesce();
         mode = $urandom_range(0, 9);
         if (mode < 3)      fft_val = CSR_W'(WIFI_FFT);
         else if (mode < 6) fft_val = CSR_W'($urandom_range(1, 160));
         else if (mode < 8) fft_val = CSR_W'($urandom_range(161, MAX_FFT));
         else if (mode < 9) fft_val = CSR_W'($urandom_range(MAX_FFT + 1, 8191));
         else               fft_val = $urandom_range(0, 1) ? CSR_W'(0) : CSR_W'(MAX_FFT);
         eff  = (int'(fft_val) > MAX_FFT) ? MAX_FFT : int'(fft_val);
         mode = $urandom_range(0, 9);
         if (mode < 7)      data_val = CSR_W'($urandom_range(0, eff));
         else if (mode < 8) data_val = CSR_W'(eff);
         else if (mode < 9) data_val = CSR_W'($urandom_range(eff, 8191));
         else               data_val = '0;
         write_csr(CSR_FFT_SIZE, fft_val);
         write_csr(CSR_DATA_SC_NUM, data_val);
         write_csr(CSR_PILOT_OFFSET, CSR_W'($urandom_range(0, 15)));
         repeat (SETTLE_CYCLES) @(posedge clock);

         // First phase: hold the receiver off while items stream in, so the
         // input side backs up and stalls.
         tx_quiet = (phase == 0) || (phase % 4 == 1);
         rx_quiet = (phase % 5 == 2);
         if (phase == 0) hold_request = 1'b1;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            typed_res = '0;
            send_carrier(pick_index(eff), 1'b0, typed_res);
         end
      end

      // Drain and let any stray result show up
      quiesce();
      repeat (10) @(posedge clock);
      if (verdict_q.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, verdict_q.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
